@@ hdl/dilp_pkg.sv @@
// Shared types and constants for the panel init list player.
// Used by dilp_decode and display_init_list_player; no dependencies.
`default_nettype none

package dilp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CntW   = 8;
  localparam int unsigned ArgW   = 7;
  localparam int unsigned KindW  = 2;
  localparam int unsigned ValueW = 9;

  localparam logic [ByteW-1:0]  DelayFlag     = 8'h80;
  localparam logic [ByteW-1:0]  DelayLongCode = 8'd255;
  localparam logic [ValueW-1:0] DelayLongMs   = 9'd500;

  typedef enum logic [KindW-1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_DELAY = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    PH_COUNT  = 6'b000001,
    PH_CMD    = 6'b000010,
    PH_ARGCNT = 6'b000100,
    PH_DELAY  = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_ENDED  = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t          phase;
    logic [CntW-1:0] cmds_left;
    logic [ArgW-1:0] args_left;
  } parse_state_t;

  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic [ValueW-1:0] value;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/dilp_decode.sv @@
// Byte classifier: next parser state and optional result for one list byte.
// Pure combinational; depends on dilp_pkg.
`default_nettype none

module dilp_decode (
  input  wire dilp_pkg::parse_state_t     st,
  input  wire logic [dilp_pkg::ByteW-1:0] list_byte,
  output dilp_pkg::parse_state_t          st_nxt,
  output dilp_pkg::result_t               res
);
  import dilp_pkg::*;

  phase_t          after_cmd;
  logic [ArgW-1:0] args_dec;

  assign after_cmd = (st.cmds_left != '0) ? PH_CMD : PH_COUNT;
  assign args_dec  = st.args_left - ArgW'(1);

  always_comb begin
    st_nxt    = st;
    res.vld   = 1'b0;
    res.kind  = KIND_CMD;
    res.value = '0;
    case (st.phase)
      PH_COUNT: begin
        if (list_byte == '0) begin
          st_nxt.phase = PH_ENDED;
          res.vld      = 1'b1;
          res.kind     = KIND_END;
        end else begin
          st_nxt.cmds_left = list_byte;
          st_nxt.phase     = PH_CMD;
        end
      end
      PH_CMD: begin
        st_nxt.cmds_left = st.cmds_left - CntW'(1);
        st_nxt.phase     = PH_ARGCNT;
        res.vld          = 1'b1;
        res.kind         = KIND_CMD;
        res.value        = ValueW'(list_byte);
      end
      PH_ARGCNT: begin
        if ((list_byte & DelayFlag) != '0) begin
          st_nxt.phase = PH_DELAY;
        end else begin
          st_nxt.args_left = list_byte[ArgW-1:0];
          st_nxt.phase     = (list_byte[ArgW-1:0] != '0) ? PH_DATA : after_cmd;
        end
      end
      PH_DELAY: begin
        st_nxt.phase = after_cmd;
        res.vld      = 1'b1;
        res.kind     = KIND_DELAY;
        res.value    = (list_byte == DelayLongCode) ? DelayLongMs : ValueW'(list_byte);
      end
      PH_DATA: begin
        st_nxt.args_left = args_dec;
        if (args_dec == '0) begin
          st_nxt.phase = after_cmd;
        end
        res.vld   = 1'b1;
        res.kind  = KIND_DATA;
        res.value = ValueW'(list_byte);
      end
      default: begin
        // ended (and any stray code): swallow everything until reset
        st_nxt.phase = PH_ENDED;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/display_init_list_player.sv @@
// Top level of the panel init list player: input register, decoder, result register.
// Depends on dilp_pkg and dilp_decode.
`default_nettype none

// Usage:
//   Feed the packed start-up list one byte per beat on in_* (in_tdata[7:0]).
//   Each byte yields zero or one result beat on out_*: out_tuser holds the
//   kind (command, data, delay, end of list), out_tdata the command/data byte
//   or the delay in ms (255 is expanded to 500).
//   Group-count bytes other than zero and argument-count bytes give no beat.
//   After the end-of-list beat every further byte is accepted and dropped.
// Timing:
//   One byte per cycle sustained while out_tready stays high. An accepted byte
//   is held in the input register and its result shows on out_tvalid from the
//   result register; the decode uses one phase register and two small counters.
// Reset:
//   rst_n low (synchronous) empties both registers and returns the parser to
//   waiting for the first group count.
// Backpressure:
//   While out_tready is low a pending result holds; the input register keeps
//   one more byte, so in_tready drops only once both stages are full.
module display_init_list_player (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] list_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [8:0] out_value, [15:9] zero
  output logic [1:0]       out_tuser   // [1:0] out_kind
);
  import dilp_pkg::*;

  logic              in_vld_r;
  logic [ByteW-1:0]  in_byte_r;
  parse_state_t      st_r;
  parse_state_t      st_nxt;
  result_t           res;
  logic              out_vld_r;
  kind_t             out_kind_r;
  logic [ValueW-1:0] out_value_r;
  logic              advance;

  dilp_decode u_decode (
    .st        (st_r),
    .list_byte (in_byte_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // the held byte moves on when the result register is free or being drained
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
      st_r.phase      <= PH_COUNT;
      st_r.cmds_left  <= '0;
      st_r.args_left  <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        st_r      <= st_nxt;
        out_vld_r <= res.vld;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (advance) begin
      out_kind_r  <= res.kind;
      out_value_r <= res.value;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_value_r};
  assign out_tuser  = out_kind_r;

endmodule

`default_nettype wire
